// ===== design/pmnr_pkg.sv =====
package pmnr_pkg;

  localparam int SOURCE_DEPTH = 256;
  localparam int MERGED_DEPTH = 256;
  localparam int UPCW = 5;

  localparam logic [2:0] OP_LOAD_A  = 3'd0;
  localparam logic [2:0] OP_LOAD_B  = 3'd1;
  localparam logic [2:0] OP_REMAP_A = 3'd2;
  localparam logic [2:0] OP_REMAP_B = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_DROPPED   = 3'd2;
  localparam logic [2:0] ST_BEYOND    = 3'd3;
  localparam logic [2:0] ST_SRC_FULL  = 3'd4;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] index;
    logic       end_of_image;
  } item_t;

  typedef struct packed {
    logic [7:0] out_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [2:0] status;
    logic [8:0] merged_count;
    logic       last_out;
  } result_t;

  typedef enum logic [2:0] {
    A_NONE,
    A_SRC_WRITE,
    A_SRC_READ,
    A_KEY_SRC,
    A_SCAN,
    A_MRG_READ_BEST,
    A_MRG_READ_IDX,
    A_CLEAR
  } act_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_DISPATCH,
    C_SRC_FULL,
    C_SCAN_MORE,
    C_IDX_BAD,
    C_MRG_EMPTY,
    C_RD_OK
  } cond_t;

  typedef enum logic [2:0] {
    RS_ZERO,
    RS_SRC_FULL,
    RS_LOAD,
    RS_BEYOND,
    RS_MRG
  } rs_t;

  typedef struct packed {
    act_t            act;
    cond_t           cond;
    logic [UPCW-1:0] target;
    logic            emit;
    rs_t             rs;
  } ctrl_t;

  typedef struct packed {
    logic src_full;
    logic scan_more;
    logic idx_bad;
    logic mrg_empty;
    logic rd_ok;
  } flags_t;

  localparam logic [UPCW-1:0] S_IDLE      = 5'd0;
  localparam logic [UPCW-1:0] S_L_CHK     = 5'd1;
  localparam logic [UPCW-1:0] S_L_SCAN    = 5'd2;
  localparam logic [UPCW-1:0] S_L_DRAIN0  = 5'd3;
  localparam logic [UPCW-1:0] S_L_DRAIN1  = 5'd4;
  localparam logic [UPCW-1:0] S_L_DRAIN2  = 5'd5;
  localparam logic [UPCW-1:0] S_L_EMIT    = 5'd6;
  localparam logic [UPCW-1:0] S_R_CHK     = 5'd7;
  localparam logic [UPCW-1:0] S_R_KEY     = 5'd8;
  localparam logic [UPCW-1:0] S_R_SCAN    = 5'd9;
  localparam logic [UPCW-1:0] S_R_DRAIN0  = 5'd10;
  localparam logic [UPCW-1:0] S_R_DRAIN1  = 5'd11;
  localparam logic [UPCW-1:0] S_R_DRAIN2  = 5'd12;
  localparam logic [UPCW-1:0] S_R_FETCH   = 5'd13;
  localparam logic [UPCW-1:0] S_E_MRG     = 5'd14;
  localparam logic [UPCW-1:0] S_E_SRCFULL = 5'd15;
  localparam logic [UPCW-1:0] S_RD_CHK    = 5'd16;
  localparam logic [UPCW-1:0] S_E_BEYOND  = 5'd17;
  localparam logic [UPCW-1:0] S_E_ZERO    = 5'd18;
  localparam logic [UPCW-1:0] S_CLEAR     = 5'd19;

  function automatic ctrl_t mk(act_t act, cond_t cond, logic [UPCW-1:0] target,
                               logic emit, rs_t rs);
    ctrl_t c;
    c.act    = act;
    c.cond   = cond;
    c.target = target;
    c.emit   = emit;
    c.rs     = rs;
    return c;
  endfunction

  function automatic ctrl_t ucode(logic [UPCW-1:0] upc);
    ctrl_t c;
    unique case (upc)
      S_IDLE:      c = mk(A_NONE, C_DISPATCH, S_IDLE, 1'b0, RS_ZERO);
      S_L_CHK:     c = mk(A_SRC_WRITE, C_SRC_FULL, S_E_SRCFULL, 1'b0, RS_ZERO);
      S_L_SCAN:    c = mk(A_SCAN, C_SCAN_MORE, S_L_SCAN, 1'b0, RS_ZERO);
      S_L_DRAIN0:  c = mk(A_NONE, C_NEXT, S_IDLE, 1'b0, RS_ZERO);
      S_L_DRAIN1:  c = mk(A_NONE, C_NEXT, S_IDLE, 1'b0, RS_ZERO);
      S_L_DRAIN2:  c = mk(A_NONE, C_NEXT, S_IDLE, 1'b0, RS_ZERO);
      S_L_EMIT:    c = mk(A_NONE, C_ALWAYS, S_IDLE, 1'b1, RS_LOAD);
      S_R_CHK:     c = mk(A_SRC_READ, C_IDX_BAD, S_E_BEYOND, 1'b0, RS_ZERO);
      S_R_KEY:     c = mk(A_KEY_SRC, C_NEXT, S_IDLE, 1'b0, RS_ZERO);
      S_R_SCAN:    c = mk(A_SCAN, C_SCAN_MORE, S_R_SCAN, 1'b0, RS_ZERO);
      S_R_DRAIN0:  c = mk(A_NONE, C_NEXT, S_IDLE, 1'b0, RS_ZERO);
      S_R_DRAIN1:  c = mk(A_NONE, C_NEXT, S_IDLE, 1'b0, RS_ZERO);
      S_R_DRAIN2:  c = mk(A_NONE, C_NEXT, S_IDLE, 1'b0, RS_ZERO);
      S_R_FETCH:   c = mk(A_MRG_READ_BEST, C_MRG_EMPTY, S_E_ZERO, 1'b0, RS_ZERO);
      S_E_MRG:     c = mk(A_NONE, C_ALWAYS, S_IDLE, 1'b1, RS_MRG);
      S_E_SRCFULL: c = mk(A_NONE, C_ALWAYS, S_IDLE, 1'b1, RS_SRC_FULL);
      S_RD_CHK:    c = mk(A_MRG_READ_IDX, C_RD_OK, S_E_MRG, 1'b0, RS_ZERO);
      S_E_BEYOND:  c = mk(A_NONE, C_ALWAYS, S_IDLE, 1'b1, RS_BEYOND);
      S_E_ZERO:    c = mk(A_NONE, C_ALWAYS, S_IDLE, 1'b1, RS_ZERO);
      S_CLEAR:     c = mk(A_CLEAR, C_ALWAYS, S_IDLE, 1'b1, RS_ZERO);
      default:     c = mk(A_NONE, C_ALWAYS, S_IDLE, 1'b0, RS_ZERO);
    endcase
    return c;
  endfunction

  function automatic logic [UPCW-1:0] dispatch(logic [2:0] op);
    logic [UPCW-1:0] s;
    unique case (op) inside
      OP_LOAD_A, OP_LOAD_B:   s = S_L_CHK;
      OP_REMAP_A, OP_REMAP_B: s = S_R_CHK;
      OP_READ:                s = S_RD_CHK;
      OP_CLEAR:               s = S_CLEAR;
      default:                s = S_E_ZERO;
    endcase
    return s;
  endfunction

endpackage

// ===== design/pmnr_useq.sv =====
module pmnr_useq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        opcode,
  input  pmnr_pkg::flags_t  flags,
  output pmnr_pkg::ctrl_t   ctrl,
  output logic              busy
);

  logic [pmnr_pkg::UPCW-1:0] upc;
  logic [pmnr_pkg::UPCW-1:0] upc_next;
  logic                      taken;

  assign ctrl = pmnr_pkg::ucode(upc);
  assign busy = (upc != pmnr_pkg::S_IDLE);

  always_comb begin
    unique case (ctrl.cond)
      pmnr_pkg::C_NEXT:      taken = 1'b0;
      pmnr_pkg::C_ALWAYS:    taken = 1'b1;
      pmnr_pkg::C_DISPATCH:  taken = 1'b0;
      pmnr_pkg::C_SRC_FULL:  taken = flags.src_full;
      pmnr_pkg::C_SCAN_MORE: taken = flags.scan_more;
      pmnr_pkg::C_IDX_BAD:   taken = flags.idx_bad;
      pmnr_pkg::C_MRG_EMPTY: taken = flags.mrg_empty;
      pmnr_pkg::C_RD_OK:     taken = flags.rd_ok;
      default:               taken = 1'b0;
    endcase
  end

  always_comb begin
    if (ctrl.cond == pmnr_pkg::C_DISPATCH) begin
      upc_next = start ? pmnr_pkg::dispatch(opcode) : upc;
    end else if (taken) begin
      upc_next = ctrl.target;
    end else begin
      upc_next = upc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= pmnr_pkg::S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ===== design/pmnr_datapath.sv =====
module pmnr_datapath #(
  parameter int SOURCE_DEPTH = pmnr_pkg::SOURCE_DEPTH,
  parameter int MERGED_DEPTH = pmnr_pkg::MERGED_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  pmnr_pkg::item_t   item,
  input  pmnr_pkg::ctrl_t   ctrl,
  output pmnr_pkg::flags_t  flags,
  output logic              done,
  output pmnr_pkg::result_t result
);

  localparam int SAW = $clog2(SOURCE_DEPTH);
  localparam int SCW = $clog2(SOURCE_DEPTH + 1);
  localparam int MAW = $clog2(MERGED_DEPTH);
  localparam int MCW = $clog2(MERGED_DEPTH + 1);

  logic [23:0] src_a [SOURCE_DEPTH];
  logic [23:0] src_b [SOURCE_DEPTH];
  logic [23:0] merged [MERGED_DEPTH];

  logic [2:0]  op;
  logic [23:0] color;
  logic [7:0]  idx;
  logic        eoi;

  logic [SCW-1:0] cnt_a;
  logic [SCW-1:0] cnt_b;
  logic [MCW-1:0] total;
  logic [MCW-1:0] total_next;
  logic [MCW-1:0] scan_idx;
  logic [MCW:0]   scan_inc;

  logic [23:0] key;
  logic [23:0] a_rdata;
  logic [23:0] b_rdata;
  logic [23:0] m_rdata;
  logic        m_re;
  logic [MAW-1:0] m_raddr;

  logic           p1_v;
  logic [MAW-1:0] p1_idx;
  logic           p2_v;
  logic [MAW-1:0] p2_idx;
  logic           p2_eq;
  logic [15:0]    sq_r;
  logic [15:0]    sq_g;
  logic [15:0]    sq_b;
  logic           p3_v;
  logic [MAW-1:0] p3_idx;
  logic           p3_eq;
  logic [17:0]    p3_dist;

  logic           found;
  logic [MAW-1:0] found_idx;
  logic           best_v;
  logic [MAW-1:0] best_idx;
  logic [17:0]    best_d;
  logic [7:0]     oidx;

  logic           sel_b;
  logic [SCW-1:0] cnt_sel;
  logic           src_full;
  logic           mrg_room;
  logic           append;
  pmnr_pkg::result_t res_next;

  function automatic logic [7:0] absdiff(logic [7:0] x, logic [7:0] y);
    return (x > y) ? (x - y) : (y - x);
  endfunction

  assign sel_b    = op[0];
  assign cnt_sel  = sel_b ? cnt_b : cnt_a;
  assign src_full = (cnt_sel == SCW'(SOURCE_DEPTH));
  assign mrg_room = (total < MCW'(MERGED_DEPTH));
  assign scan_inc = {1'b0, scan_idx} + {{MCW{1'b0}}, 1'b1};

  assign flags.src_full  = src_full;
  assign flags.scan_more = (scan_inc < {1'b0, total});
  assign flags.idx_bad   = ({1'b0, idx} >= 9'(cnt_sel));
  assign flags.mrg_empty = (total == '0);
  assign flags.rd_ok     = ({1'b0, idx} < 9'(total));

  assign append = ctrl.emit && (ctrl.rs == pmnr_pkg::RS_LOAD) && !found && mrg_room;

  always_comb begin
    if (ctrl.act == pmnr_pkg::A_CLEAR) begin
      total_next = '0;
    end else if (append) begin
      total_next = total + 1'b1;
    end else begin
      total_next = total;
    end
  end

  always_comb begin
    m_re    = 1'b0;
    m_raddr = scan_idx[MAW-1:0];
    unique case (ctrl.act)
      pmnr_pkg::A_SCAN: begin
        m_re = 1'b1;
      end
      pmnr_pkg::A_MRG_READ_BEST: begin
        m_re    = 1'b1;
        m_raddr = best_idx;
      end
      pmnr_pkg::A_MRG_READ_IDX: begin
        m_re    = 1'b1;
        m_raddr = idx[MAW-1:0];
      end
      default: begin
        m_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= item.opcode;
      color <= {item.red, item.green, item.blue};
      idx   <= item.index;
      eoi   <= item.end_of_image;
    end
    if (ctrl.act == pmnr_pkg::A_SRC_WRITE && !src_full) begin
      if (sel_b) begin
        src_b[cnt_b[SAW-1:0]] <= color;
      end else begin
        src_a[cnt_a[SAW-1:0]] <= color;
      end
    end
    if (ctrl.act == pmnr_pkg::A_SRC_READ) begin
      a_rdata <= src_a[idx[SAW-1:0]];
      b_rdata <= src_b[idx[SAW-1:0]];
    end
    if (append) begin
      merged[total[MAW-1:0]] <= key;
    end
    if (m_re) begin
      m_rdata <= merged[m_raddr];
    end
    if (ctrl.act == pmnr_pkg::A_SRC_WRITE) begin
      key <= color;
    end else if (ctrl.act == pmnr_pkg::A_KEY_SRC) begin
      key <= sel_b ? b_rdata : a_rdata;
    end
    if (ctrl.act == pmnr_pkg::A_MRG_READ_BEST) begin
      oidx <= 8'(best_idx);
    end else if (ctrl.act == pmnr_pkg::A_MRG_READ_IDX) begin
      oidx <= idx;
    end
    p1_idx  <= scan_idx[MAW-1:0];
    p2_idx  <= p1_idx;
    p2_eq   <= (m_rdata == key);
    sq_r    <= 16'(absdiff(m_rdata[23:16], key[23:16])) *
               16'(absdiff(m_rdata[23:16], key[23:16]));
    sq_g    <= 16'(absdiff(m_rdata[15:8], key[15:8])) *
               16'(absdiff(m_rdata[15:8], key[15:8]));
    sq_b    <= 16'(absdiff(m_rdata[7:0], key[7:0])) *
               16'(absdiff(m_rdata[7:0], key[7:0]));
    p3_idx  <= p2_idx;
    p3_eq   <= p2_eq;
    p3_dist <= 18'(sq_r) + 18'(sq_g) + 18'(sq_b);
    if (p3_v && p3_eq && !found) begin
      found_idx <= p3_idx;
    end
    if (p3_v && (!best_v || p3_dist < best_d)) begin
      best_idx <= p3_idx;
      best_d   <= p3_dist;
    end
    result <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a    <= '0;
      cnt_b    <= '0;
      total    <= '0;
      scan_idx <= '0;
      p1_v     <= 1'b0;
      p2_v     <= 1'b0;
      p3_v     <= 1'b0;
      found    <= 1'b0;
      best_v   <= 1'b0;
      done     <= 1'b0;
    end else begin
      total <= total_next;
      p1_v  <= (ctrl.act == pmnr_pkg::A_SCAN) && (scan_idx < total);
      p2_v  <= p1_v;
      p3_v  <= p2_v;
      done  <= ctrl.emit;
      if (ctrl.act == pmnr_pkg::A_CLEAR) begin
        cnt_a <= '0;
        cnt_b <= '0;
      end else if (ctrl.act == pmnr_pkg::A_SRC_WRITE && !src_full) begin
        if (sel_b) begin
          cnt_b <= cnt_b + 1'b1;
        end else begin
          cnt_a <= cnt_a + 1'b1;
        end
      end
      if (ctrl.act == pmnr_pkg::A_SRC_WRITE || ctrl.act == pmnr_pkg::A_KEY_SRC) begin
        scan_idx <= '0;
        found    <= 1'b0;
        best_v   <= 1'b0;
      end else begin
        if (ctrl.act == pmnr_pkg::A_SCAN) begin
          scan_idx <= scan_inc[MCW-1:0];
        end
        if (p3_v && p3_eq) begin
          found <= 1'b1;
        end
        if (p3_v) begin
          best_v <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_next.out_index    = '0;
    res_next.out_red      = '0;
    res_next.out_green    = '0;
    res_next.out_blue     = '0;
    res_next.status       = pmnr_pkg::ST_OK;
    res_next.merged_count = 9'(total_next);
    res_next.last_out     = eoi;
    unique case (ctrl.rs)
      pmnr_pkg::RS_ZERO: begin
        res_next.status = pmnr_pkg::ST_OK;
      end
      pmnr_pkg::RS_SRC_FULL: begin
        res_next.status = pmnr_pkg::ST_SRC_FULL;
      end
      pmnr_pkg::RS_LOAD: begin
        if (found) begin
          res_next.out_index = 8'(found_idx);
          {res_next.out_red, res_next.out_green, res_next.out_blue} = key;
          res_next.status    = pmnr_pkg::ST_DUPLICATE;
        end else if (mrg_room) begin
          res_next.out_index = 8'(total);
          {res_next.out_red, res_next.out_green, res_next.out_blue} = key;
        end else begin
          res_next.status = pmnr_pkg::ST_DROPPED;
        end
      end
      pmnr_pkg::RS_BEYOND: begin
        res_next.out_index = (op == pmnr_pkg::OP_READ) ? idx : 8'd0;
        res_next.status    = pmnr_pkg::ST_BEYOND;
      end
      pmnr_pkg::RS_MRG: begin
        res_next.out_index = oidx;
        {res_next.out_red, res_next.out_green, res_next.out_blue} = m_rdata;
      end
      default: begin
        res_next.status = pmnr_pkg::ST_OK;
      end
    endcase
  end

endmodule

// ===== design/palette_merge_nearest_remap.sv =====
// One command is taken when start is high and busy is low, and exactly one result beat
// follows on result, marked by a one-cycle done strobe that the receiver cannot hold off.
// A load scans the merged palette once it is taken, and a remap first fetches the source
// color and then scans. A read, a load into a full source palette, a remap of an index
// beyond the loaded colors, a clear and an undefined opcode make no scan. Busy drops at
// the edge that raises the strobe, so the next command can be taken while the strobe is
// high. The time is set by the scan of the merged palette memory, one entry per cycle into
// a four-stage compare pipeline, under a small microcoded sequencer. Data read from
// entries of the source and merged palettes before they are written is never used, so
// there is no clearing pass after reset.
module palette_merge_nearest_remap #(
  parameter int SOURCE_DEPTH = pmnr_pkg::SOURCE_DEPTH,
  parameter int MERGED_DEPTH = pmnr_pkg::MERGED_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pmnr_pkg::item_t   item,
  output logic              done,
  output pmnr_pkg::result_t result
);

  pmnr_pkg::ctrl_t  ctrl;
  pmnr_pkg::flags_t flags;
  logic             accept;

  assign accept = start && !busy;

  pmnr_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (item.opcode),
    .flags  (flags),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  pmnr_datapath #(
    .SOURCE_DEPTH (SOURCE_DEPTH),
    .MERGED_DEPTH (MERGED_DEPTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .ctrl   (ctrl),
    .flags  (flags),
    .done   (done),
    .result (result)
  );

endmodule

// ===== tb/sv/pmnr_palette_check.sv =====
module pmnr_palette_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  pmnr_pkg::item_t   item,
  input  logic              done,
  input  pmnr_pkg::result_t result,
  output int                fail_count,
  output int                results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [23:0]       palette_a [pmnr_pkg::SOURCE_DEPTH];
  logic [23:0]       palette_b [pmnr_pkg::SOURCE_DEPTH];
  logic [23:0]       shared_palette [pmnr_pkg::MERGED_DEPTH];
  int unsigned       count_a;
  int unsigned       count_b;
  int unsigned       shared_used;
  pmnr_pkg::result_t results_due [$];
  pmnr_pkg::result_t want;
  pmnr_pkg::result_t due;
  bit                ok;

  function automatic int rgb_dist(logic [23:0] p, logic [23:0] q);
    int sum;
    int d;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      d = int'(p[8*k +: 8]) - int'(q[8*k +: 8]);
      sum += d * d;
    end
    return sum;
  endfunction

  function automatic pmnr_pkg::result_t predict_result(pmnr_pkg::item_t it);
    pmnr_pkg::result_t r;
    logic [23:0]       col;
    logic [23:0]       src_col;
    int                found;
    int                best;
    int                best_dist;
    int                d;
    int unsigned       loaded;
    r = '0;
    r.last_out = it.end_of_image;
    col = {it.red, it.green, it.blue};
    case (it.opcode) inside
      pmnr_pkg::OP_LOAD_A, pmnr_pkg::OP_LOAD_B: begin
        loaded = (it.opcode == pmnr_pkg::OP_LOAD_A) ? count_a : count_b;
        if (loaded >= pmnr_pkg::SOURCE_DEPTH) begin
          r.status = pmnr_pkg::ST_SRC_FULL;
        end else begin
          if (it.opcode == pmnr_pkg::OP_LOAD_A) begin
            palette_a[count_a] = col;
            count_a++;
          end else begin
            palette_b[count_b] = col;
            count_b++;
          end
          found = -1;
          for (int i = 0; i < shared_used; i++) begin
            if (found < 0 && shared_palette[i] == col) found = i;
          end
          if (found >= 0) begin
            r.out_index = 8'(found);
            {r.out_red, r.out_green, r.out_blue} = col;
            r.status = pmnr_pkg::ST_DUPLICATE;
          end else if (shared_used < pmnr_pkg::MERGED_DEPTH) begin
            shared_palette[shared_used] = col;
            r.out_index = 8'(shared_used);
            {r.out_red, r.out_green, r.out_blue} = col;
            shared_used++;
          end else begin
            r.status = pmnr_pkg::ST_DROPPED;
          end
        end
      end
      pmnr_pkg::OP_REMAP_A, pmnr_pkg::OP_REMAP_B: begin
        loaded = (it.opcode == pmnr_pkg::OP_REMAP_A) ? count_a : count_b;
        if (it.index >= loaded) begin
          r.status = pmnr_pkg::ST_BEYOND;
        end else if (shared_used > 0) begin
          src_col = (it.opcode == pmnr_pkg::OP_REMAP_A) ? palette_a[it.index]
                                                         : palette_b[it.index];
          best = 0;
          best_dist = rgb_dist(src_col, shared_palette[0]);
          for (int i = 1; i < shared_used; i++) begin
            d = rgb_dist(src_col, shared_palette[i]);
            if (d < best_dist) begin
              best_dist = d;
              best = i;
            end
          end
          r.out_index = 8'(best);
          {r.out_red, r.out_green, r.out_blue} = shared_palette[best];
        end
      end
      pmnr_pkg::OP_READ: begin
        r.out_index = it.index;
        if (it.index >= shared_used) begin
          r.status = pmnr_pkg::ST_BEYOND;
        end else begin
          {r.out_red, r.out_green, r.out_blue} = shared_palette[it.index];
        end
      end
      pmnr_pkg::OP_CLEAR: begin
        count_a = 0;
        count_b = 0;
        shared_used = 0;
      end
      default: begin
      end
    endcase
    r.merged_count = 9'(shared_used);
    return r;
  endfunction

  function automatic bit field_ok(string name, logic [8:0] expected_val, logic [8:0] actual_val);
    if (actual_val !== expected_val) begin
      $error("%s expected %0d actual %0d", name, expected_val, actual_val);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      count_a = 0;
      count_b = 0;
      shared_used = 0;
      results_due.delete();
    end else begin
      if (done) begin
        if (results_due.size() == 0) begin
          $error("result beat with no command waiting for it");
          fail_count++;
        end else begin
          want = results_due.pop_front();
          ok = field_ok("out_index", 9'(want.out_index), 9'(result.out_index))
             & field_ok("out_red", 9'(want.out_red), 9'(result.out_red))
             & field_ok("out_green", 9'(want.out_green), 9'(result.out_green))
             & field_ok("out_blue", 9'(want.out_blue), 9'(result.out_blue))
             & field_ok("status", 9'(want.status), 9'(result.status))
             & field_ok("merged_count", want.merged_count, result.merged_count)
             & field_ok("last_out", 9'(want.last_out), 9'(result.last_out));
          if (!ok) fail_count++;
        end
      end
      if (start && !busy) begin
        due = predict_result(item);
        results_due = {results_due, due};
      end
    end
    results_pending = results_due.size();
  end

endmodule

// ===== tb/sv/palette_merge_nearest_remap_tb.sv =====
module palette_merge_nearest_remap_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET      = 1550;
  localparam int QUIET_TAIL       = 200;
  localparam int STALL_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 300;
  localparam int BIG_SESSION_ROOM = 400;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  pmnr_pkg::item_t   item = '0;
  logic              busy;
  logic              done;
  pmnr_pkg::result_t result;

  int fail_count;
  int results_pending;
  int beats_sent = 0;
  bit gaps_on = 1'b1;
  int stall_cycles = 0;
  int loaded_a = 0;
  int loaded_b = 0;
  logic [23:0] session_colors [$];

  palette_merge_nearest_remap dut (
    .clk, .rst, .start, .busy, .item, .done, .result
  );

  pmnr_palette_check watch (
    .clk, .rst, .start, .busy, .item, .done, .result, .fail_count, .results_pending
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic pmnr_pkg::item_t make_item(logic [2:0] op, logic [23:0] col,
                                                logic [7:0] idx, logic eoi);
    pmnr_pkg::item_t it;
    it.opcode = op;
    {it.red, it.green, it.blue} = col;
    it.index = idx;
    it.end_of_image = eoi;
    return it;
  endfunction

  function automatic logic [23:0] random_color(int coarse_pct);
    logic [23:0] c;
    int lvl;
    c = 24'($urandom);
    if ($urandom_range(0, 99) < coarse_pct) begin
      for (int k = 0; k < 3; k++) begin
        lvl = $urandom_range(0, 4);
        c[8*k +: 8] = (lvl == 4) ? 8'hff : 8'(lvl * 64);
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] pixel_index(int loaded);
    if (loaded <= 0 || $urandom_range(0, 9) == 0) return 8'($urandom);
    return 8'($urandom_range(0, (loaded > 256 ? 256 : loaded) - 1));
  endfunction

  task automatic send_beat(input pmnr_pkg::item_t it);
    if (beats_sent >= ITEM_TARGET - QUIET_TAIL) gaps_on = 1'b0;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  task automatic load_color(input logic [2:0] op, input int reuse_pct, input int coarse_pct);
    logic [23:0] col;
    if (session_colors.size() != 0 && $urandom_range(0, 99) < reuse_pct)
      col = session_colors[$urandom_range(0, session_colors.size() - 1)];
    else
      col = random_color(coarse_pct);
    session_colors = {session_colors, col};
    send_beat(make_item(op, col, 8'($urandom), $urandom_range(0, 9) == 0));
    if (op == pmnr_pkg::OP_LOAD_A) loaded_a++;
    else loaded_b++;
  endtask

  task automatic run_session(input bit big);
    int na;
    int nb;
    int nmix;
    int pick;
    logic eoi;
    if (big) begin
      na = pmnr_pkg::SOURCE_DEPTH + $urandom_range(1, 3);
      nb = $urandom_range(10, 20);
      nmix = $urandom_range(30, 50);
    end else begin
      na = $urandom_range(1, 24);
      nb = $urandom_range(0, 24);
      nmix = $urandom_range(10, 40);
    end
    if (big || $urandom_range(0, 4) != 0) begin
      send_beat(make_item(pmnr_pkg::OP_CLEAR, 24'($urandom), 8'($urandom), 1'b0));
      loaded_a = 0;
      loaded_b = 0;
      session_colors.delete();
    end
    repeat (na) load_color(pmnr_pkg::OP_LOAD_A, big ? 0 : 25, big ? 0 : 30);
    repeat (nb) load_color(pmnr_pkg::OP_LOAD_B, 40, 30);
    for (int n = 0; n < nmix; n++) begin
      pick = $urandom_range(0, 99);
      eoi = (n == nmix - 1) || ($urandom_range(0, 7) == 0);
      if (pick < 35)
        send_beat(make_item(pmnr_pkg::OP_REMAP_A, 24'($urandom), pixel_index(loaded_a), eoi));
      else if (pick < 70)
        send_beat(make_item(pmnr_pkg::OP_REMAP_B, 24'($urandom), pixel_index(loaded_b), eoi));
      else if (pick < 85)
        send_beat(make_item(pmnr_pkg::OP_READ, 24'($urandom),
                            pixel_index(loaded_a + loaded_b), eoi));
      else if (pick < 93)
        load_color(($urandom_range(0, 1) == 0) ? pmnr_pkg::OP_LOAD_A : pmnr_pkg::OP_LOAD_B,
                   30, 30);
      else
        send_beat(make_item(3'($urandom), 24'($urandom), 8'($urandom), 1'($urandom)));
    end
  endtask

  initial begin
    int session_no;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_beat(make_item(pmnr_pkg::OP_REMAP_A, 24'h000000, 8'd0, 1'b0));
    send_beat(make_item(pmnr_pkg::OP_READ, 24'h000000, 8'd0, 1'b1));
    send_beat(make_item(pmnr_pkg::OP_LOAD_A, 24'h000000, 8'hff, 1'b0));
    send_beat(make_item(pmnr_pkg::OP_LOAD_A, 24'hffffff, 8'h00, 1'b1));
    send_beat(make_item(pmnr_pkg::OP_LOAD_A, 24'h000000, 8'h55, 1'b0));
    send_beat(make_item(pmnr_pkg::OP_LOAD_B, 24'hffffff, 8'haa, 1'b0));
    send_beat(make_item(pmnr_pkg::OP_LOAD_B, 24'h808080, 8'h00, 1'b0));
    send_beat(make_item(pmnr_pkg::OP_LOAD_B, 24'h7f7f7f, 8'hff, 1'b1));
    send_beat(make_item(pmnr_pkg::OP_REMAP_A, 24'hffffff, 8'd0, 1'b0));
    send_beat(make_item(pmnr_pkg::OP_REMAP_A, 24'h000000, 8'd2, 1'b1));
    send_beat(make_item(pmnr_pkg::OP_REMAP_B, 24'h000000, 8'd1, 1'b0));
    send_beat(make_item(pmnr_pkg::OP_REMAP_B, 24'hffffff, 8'd2, 1'b0));
    send_beat(make_item(pmnr_pkg::OP_REMAP_B, 24'h000000, 8'd3, 1'b1));
    send_beat(make_item(pmnr_pkg::OP_REMAP_A, 24'h000000, 8'd255, 1'b0));
    send_beat(make_item(pmnr_pkg::OP_READ, 24'hffffff, 8'd0, 1'b0));
    send_beat(make_item(pmnr_pkg::OP_READ, 24'h000000, 8'd3, 1'b0));
    send_beat(make_item(pmnr_pkg::OP_READ, 24'h000000, 8'd4, 1'b1));
    send_beat(make_item(pmnr_pkg::OP_READ, 24'h000000, 8'd255, 1'b0));
    send_beat(make_item(3'd6, 24'h5a5a5a, 8'h5a, 1'b0));
    send_beat(make_item(3'd7, 24'hffffff, 8'hff, 1'b1));
    send_beat(make_item(pmnr_pkg::OP_CLEAR, 24'hffffff, 8'hff, 1'b0));
    send_beat(make_item(pmnr_pkg::OP_REMAP_B, 24'h000000, 8'd0, 1'b0));
    send_beat(make_item(pmnr_pkg::OP_READ, 24'h000000, 8'd0, 1'b1));

    session_no = 0;
    while (beats_sent < ITEM_TARGET) begin
      run_session(session_no % 12 == 5 && beats_sent < ITEM_TARGET - BIG_SESSION_ROOM);
      session_no++;
    end
    start <= 1'b0;

    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/pmnr_pkg.sv
design/pmnr_useq.sv
design/pmnr_datapath.sv
design/palette_merge_nearest_remap.sv
tb/sv/pmnr_palette_check.sv
tb/sv/palette_merge_nearest_remap_tb.sv
